[src/assert_macros.svh]
// Assertion helpers shared by the decoder unit modules.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked outside reset.
`define PIOCD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define PIOCD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

[src/piocd_pkg.sv]
// ----------------------------------------------------------------------------
// piocd_pkg
// Types, codes and constants of the parallel I/O card decoder unit.
// ----------------------------------------------------------------------------
`default_nettype none

package piocd_pkg;

   localparam int TERM_W      = 3;
   localparam int BYTE_W      = 8;
   localparam int ADDR_W      = 16;
   localparam int OP_W        = 2;
   localparam int MODE_W      = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [BYTE_W-1:0] ACK_TICKS = 8'd200;

   // bus operations
   localparam logic [OP_W-1:0] OP_READ   = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
   localparam logic [OP_W-1:0] OP_STROBE = 2'd2;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd3;

   // card modes
   localparam logic [MODE_W-1:0] MODE_4IN_4OUT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_8IN      = 2'd1;
   localparam logic [MODE_W-1:0] MODE_8OUT     = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CARD_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDR_SEL  = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] bus_address;
      logic [TERM_W-1:0] strobe_terminal;
      logic [BYTE_W-1:0] strobe_data;
   } req_type;

   typedef struct packed {
      logic              addressed;
      logic [BYTE_W-1:0] read_data;
      logic              write_done;
      logic [TERM_W-1:0] out_terminal;
      logic [BYTE_W-1:0] out_data;
      logic [BYTE_W-1:0] ack_lines;
      logic              direction_error;
   } rsp_type;

   // classified item passed from the front end to the back end
   typedef struct packed {
      logic              addressed;
      logic              dir_err;
      logic              do_read;
      logic [TERM_W-1:0] rd_term;
      logic              do_write;
      logic [TERM_W-1:0] wr_term;
      logic [BYTE_W-1:0] wr_data;
      logic              do_strobe;
      logic [TERM_W-1:0] st_term;
      logic [BYTE_W-1:0] st_data;
      logic              do_tick;
   } cmd_type;

endpackage

`default_nettype wire

[src/piocd_front.sv]
// ----------------------------------------------------------------------------
// piocd_front
// Holds the configuration registers and classifies each request beat into
// a command: address match, terminal choice and direction check.
// ----------------------------------------------------------------------------
`default_nettype none

module piocd_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [piocd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [piocd_pkg::BYTE_W-1:0] csr_wdata,
   input  wire piocd_pkg::req_type           req_data,
   output piocd_pkg::cmd_type                cmd
);
   import piocd_pkg::*;

   logic [MODE_W-1:0] mode_ff;
   logic [MODE_W-1:0] mode_in;
   logic [BYTE_W-1:0] sel_ff;
   logic [BYTE_W-1:0] sel_in;

   logic [ADDR_W-1:0] a;
   logic [TERM_W:0]   owned;
   logic              rd_match;
   logic              wr_match;
   logic [TERM_W-1:0] rd_term;
   logic              rd_owned;
   logic              st_owned;

   assign csr_ready = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      sel_in  = sel_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CARD_MODE: mode_in = csr_wdata[MODE_W-1:0];
            CSR_ADDR_SEL:  sel_in  = csr_wdata;
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
         sel_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         sel_ff  <= sel_in;
      end
   end

   assign a = req_data.bus_address;

   always_comb begin
      case (mode_ff)
         MODE_4IN_4OUT: owned = 4'd4;
         MODE_8IN:      owned = 4'd8;
         default:       owned = 4'd0;
      endcase
   end

   // address match per mode and direction
   always_comb begin
      case (mode_ff)
         MODE_4IN_4OUT: begin
            rd_match = (a[11:9] == 3'b000) && (a[2] == sel_ff[0]);
            wr_match = (a[13:11] == sel_ff[7:5]);
         end
         MODE_8IN: begin
            rd_match = ({a[11:9], a[7:3]} == sel_ff);
            wr_match = rd_match;
         end
         MODE_8OUT: begin
            rd_match = ({a[13:12], 6'b000000} == sel_ff);
            wr_match = rd_match;
         end
         default: begin
            rd_match = 1'b0;
            wr_match = 1'b0;
         end
      endcase
   end

   // in 4-in/4-out mode, shift the read terminal down by four when the selection picks the upper half
   always_comb begin
      rd_term = a[TERM_W-1:0];
      if ((mode_ff == MODE_4IN_4OUT) && sel_ff[0])
         rd_term = a[TERM_W-1:0] - 3'd4;
   end

   assign rd_owned = ({1'b0, rd_term} < owned);
   assign st_owned = ({1'b0, req_data.strobe_terminal} < owned);

   always_comb begin
      cmd           = '0;
      cmd.rd_term   = rd_term;
      cmd.wr_data   = a[BYTE_W-1:0];
      cmd.st_term   = req_data.strobe_terminal;
      cmd.st_data   = req_data.strobe_data;
      cmd.wr_term   = (mode_ff == MODE_4IN_4OUT) ? {1'b1, a[10:9]} : a[11:9];
      case (req_data.op)
         OP_READ: begin
            if (rd_match) begin
               cmd.addressed = 1'b1;
               cmd.do_read   = rd_owned;
               cmd.dir_err   = !rd_owned;
            end
         end
         OP_WRITE: begin
            if (wr_match) begin
               cmd.addressed = 1'b1;
               if ((mode_ff == MODE_4IN_4OUT) || (mode_ff == MODE_8OUT))
                  cmd.do_write = 1'b1;
               else
                  cmd.dir_err  = 1'b1;
            end
         end
         OP_STROBE: begin
            cmd.do_strobe = st_owned;
            cmd.dir_err   = !st_owned;
         end
         OP_TICK: cmd.do_tick = 1'b1;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

[src/piocd_queue.sv]
// ----------------------------------------------------------------------------
// piocd_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module piocd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire piocd_pkg::cmd_type push_cmd,
   output logic                    full,
   input  wire logic               pop,
   output logic                    head_valid,
   output piocd_pkg::cmd_type      head_cmd
);
   import piocd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;

   assign full       = (cnt_ff == DEPTH_CNT);
   assign head_valid = (cnt_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= push_cmd;
   end

   `PIOCD_ASSERT_IMP(a_no_overflow, full, !push, "push into a full command queue")
   `PIOCD_ASSERT_IMP(a_no_underflow, pop, head_valid, "pop from an empty command queue")
   `PIOCD_ASSERT(a_cnt_bound, cnt_ff <= DEPTH_CNT, "command queue count out of range")

endmodule

`default_nettype wire

[src/piocd_back.sv]
// ----------------------------------------------------------------------------
// piocd_back
// Executes queued commands against the terminal latches and acknowledge
// countdowns, and holds the result beat in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module piocd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_valid,
   input  wire piocd_pkg::cmd_type head_cmd,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output piocd_pkg::rsp_type      rsp_data
);
   import piocd_pkg::*;

   localparam int TERMS = 2 ** TERM_W;

   logic [BYTE_W-1:0] latch_ff [TERMS];
   logic [BYTE_W-1:0] latch_in [TERMS];
   logic [BYTE_W-1:0] cnt_ff   [TERMS];
   logic [BYTE_W-1:0] cnt_in   [TERMS];
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   // advance when the output register is empty or being taken
   assign pop = head_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      for (int t = 0; t < TERMS; t++) begin
         latch_in[t] = latch_ff[t];
         cnt_in[t]   = cnt_ff[t];
         if (head_cmd.do_tick && (cnt_ff[t] != '0))
            cnt_in[t] = cnt_ff[t] - 1'b1;
      end
      if (head_cmd.do_strobe)
         latch_in[head_cmd.st_term] = head_cmd.st_data;
      if (head_cmd.do_write)
         cnt_in[head_cmd.wr_term] = ACK_TICKS;
   end

   always_comb begin
      rsp_in                 = '0;
      rsp_in.addressed       = head_cmd.addressed;
      rsp_in.direction_error = head_cmd.dir_err;
      if (head_cmd.do_read)
         rsp_in.read_data = latch_ff[head_cmd.rd_term];
      if (head_cmd.do_write) begin
         rsp_in.write_done   = 1'b1;
         rsp_in.out_terminal = head_cmd.wr_term;
         rsp_in.out_data     = head_cmd.wr_data;
      end
      for (int t = 0; t < TERMS; t++)
         rsp_in.ack_lines[t] = (cnt_in[t] != '0);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_valid_ff || !rsp_stall)
         rsp_valid_in = head_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t < TERMS; t++) begin
            latch_ff[t] <= '0;
            cnt_ff[t]   <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            for (int t = 0; t < TERMS; t++) begin
               latch_ff[t] <= latch_in[t];
               cnt_ff[t]   <= cnt_in[t];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop)
         rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PIOCD_ASSERT_IMP(a_write_acks, rsp_valid_ff && rsp_ff.write_done,
      rsp_ff.ack_lines[rsp_ff.out_terminal], "written terminal has no acknowledge raised")
   `PIOCD_ASSERT_IMP(a_write_no_err, rsp_valid_ff && rsp_ff.write_done,
      rsp_ff.addressed && !rsp_ff.direction_error, "write result flagged inconsistently")
   `PIOCD_ASSERT_IMP(a_read_needs_addr, rsp_valid_ff && (rsp_ff.read_data != '0),
      rsp_ff.addressed, "read data returned for an unaddressed beat")

endmodule

`default_nettype wire

[src/parallel_io_card_decoder_unit.sv]
// ----------------------------------------------------------------------------
// parallel_io_card_decoder_unit
// Byte I/O card decoder: address match, input latching and output writes
// with per-terminal acknowledge countdowns.
// ----------------------------------------------------------------------------
// Path: a request beat is written into the command queue, then into the output
//   register, from which its result beat is taken.
// Throughput: one request beat per cycle while req_stall (queue full) is low;
//   the two-entry command queue lets requests keep flowing for two beats while the result is stalled.
// Reset (synchronous, active high) clears mode, selection, all latches and
//   countdowns, and empties the queue and output register.
`default_nettype none

module parallel_io_card_decoder_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire piocd_pkg::req_type              req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output piocd_pkg::rsp_type                   rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [piocd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [piocd_pkg::BYTE_W-1:0]    csr_wdata
);
   import piocd_pkg::*;

   cmd_type front_cmd;
   cmd_type head_cmd;
   logic    q_full;
   logic    q_push;
   logic    q_pop;
   logic    head_valid;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   piocd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (front_cmd)
   );

   piocd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (front_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   piocd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
